### hdl/usbet_pkg.sv
// Shared types and constants for the USB endpoint transfer engine.
`timescale 1ns / 1ps
package usbet_pkg;

    localparam int NUM_ENDPOINTS_DEF = 16;
    localparam int LENGTH_BITS_DEF   = 16;
    localparam int MAXP_W            = 10;
    localparam int EP_W              = 4;
    localparam int CMD_W             = 3;
    localparam int S_TDATA_W         = 48;
    localparam int M_TDATA_W         = 56;

    typedef enum logic [CMD_W-1:0] {
        CMD_INIT      = 3'd0,
        CMD_START_IN  = 3'd1,
        CMD_START_OUT = 3'd2,
        CMD_BUF_DONE  = 3'd3,
        CMD_SETUP     = 3'd4,
        CMD_CLEAR     = 3'd5
    } cmd_t;

    typedef enum logic {
        KIND_ARMED    = 1'b0,
        KIND_COMPLETE = 1'b1
    } kind_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_EXEC,
        S_DIV,
        S_ARM_IN,
        S_ARM_OUT,
        S_EMIT,
        S_WB
    } state_t;

endpackage

### hdl/usbet_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module usbet_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hdl/usbet_div.sv
// Restoring divider, one quotient bit per cycle, for the OUT packet count.
`timescale 1ns / 1ps
module usbet_div #(
    parameter int DW = 17,
    parameter int VW = 10
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient
);

    localparam int CNT_W = $clog2(DW);

    logic [VW-1:0]    rem_reg;
    logic [DW-1:0]    num_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             run_reg;
    logic             done_reg;

    logic [VW:0] trial;
    logic [VW:0] diff;
    logic        ge;

    // One restoring step
    always_comb
    begin
        trial = {rem_reg, num_reg[DW-1]};
        diff  = trial - {1'b0, divisor};
        ge    = (trial >= {1'b0, divisor});
    end

    // Control: run for DW steps, then pulse done
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                if (cnt_reg == CNT_W'(DW - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // Datapath: partial remainder and dividend/quotient shift register
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            num_reg <= dividend;
        end
        else if (run_reg)
        begin
            rem_reg <= ge ? diff[VW-1:0] : trial[VW-1:0];
            num_reg <= {num_reg[DW-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = num_reg;

endmodule

### hdl/usb_endpoint_transfer_engine_top.sv
// Top level of the USB endpoint transfer engine: command decode, state table, result output.
//
// Usage:
//   Commands enter on the s_ stream (s_tuser = command, s_tdata = endpoint,
//   direction and lengths). Results leave on the m_ stream (m_tuser = result
//   kind, m_tlast = last result of the command). One command is worked at a time;
//   s_tready is high only while the engine is idle.
//   Init, setup and clear toggle finish in the accept cycle and give no result.
//   Start in, start out and buffer done read the endpoint record and the max
//   packet entry from two RAMs, execute, give one or two results, then write
//   the record back. A start out with a nonzero length and max packet size
//   adds the packet-count divider, which holds the engine while it works
//   (one quotient bit per cycle, then done).
//   A stalled receiver holds the result in the output register; the engine
//   waits there and takes no new command until the beat is taken.
//   Reset clears all toggles and marks every endpoint record as zero; max
//   packet sizes are undefined until an init command writes them.
`timescale 1ns / 1ps
module usb_endpoint_transfer_engine_top #(
    parameter int NUM_ENDPOINTS = usbet_pkg::NUM_ENDPOINTS_DEF,
    parameter int LENGTH_BITS   = usbet_pkg::LENGTH_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [3:0] endpoint, [4] is_in, [14:5] max_packet, [30:15] transfer_length,
    // [40:31] received_length, [47:41] zero
    input  logic [usbet_pkg::S_TDATA_W-1:0]  s_tdata,
    // [2:0] command
    input  logic [usbet_pkg::CMD_W-1:0]      s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [3:0] endpoint_out, [4] direction_in, [5] buffer_select, [15:6] buffer_length,
    // [16] data_pid, [17] final_buffer, [18] buffer_full, [34:19] user_offset,
    // [35] double_buffered, [51:36] transferred_count, [55:52] zero
    output logic [usbet_pkg::M_TDATA_W-1:0]  m_tdata,
    // [0] result_kind
    output logic                             m_tuser,
    // last_of_run
    output logic                             m_tlast
);

    import usbet_pkg::*;

    localparam int LB    = LENGTH_BITS;
    localparam int EPW   = (NUM_ENDPOINTS > 1) ? $clog2(NUM_ENDPOINTS) : 1;
    localparam int TIW   = EPW + 1;
    localparam int NT    = 2 * NUM_ENDPOINTS;
    localparam int REC_W = 5 * LB;
    localparam int CW    = (LB > MAXP_W) ? LB : MAXP_W;
    localparam int DW    = CW + 1;

    // Input fields
    logic [EP_W-1:0]   in_ep;
    logic              in_dir;
    logic [MAXP_W-1:0] in_maxp;
    logic [15:0]       in_tlen;
    logic [MAXP_W-1:0] in_rlen;
    cmd_t              in_cmd;
    logic              in_fire;
    logic              in_ep_ok;

    assign in_ep    = s_tdata[3:0];
    assign in_dir   = s_tdata[4];
    assign in_maxp  = s_tdata[14:5];
    assign in_tlen  = s_tdata[30:15];
    assign in_rlen  = s_tdata[40:31];
    assign in_cmd   = cmd_t'(s_tuser);
    assign in_ep_ok = ({1'b0, in_ep} < 5'(NUM_ENDPOINTS));

    state_t state_reg, state_next;

    // Command registers
    cmd_t              cmd_reg, cmd_next;
    logic [EPW-1:0]    ep_reg, ep_next;
    logic              dir_reg, dir_next;
    logic [LB-1:0]     tlen_reg, tlen_next;
    logic [MAXP_W-1:0] rlen_reg, rlen_next;

    // Working copy of the endpoint record
    logic [LB-1:0]     total_reg, total_next;
    logic [LB-1:0]     queued_reg, queued_next;
    logic [LB-1:0]     rrem_reg, rrem_next;
    logic [LB-1:0]     rrecv_reg, rrecv_next;
    logic [LB-1:0]     pleft_reg, pleft_next;
    logic [MAXP_W-1:0] lim_reg, lim_next;

    logic              second_reg, second_next;
    logic              pending_reg, pending_next;
    logic [NT-1:0]     toggle_reg, toggle_next;
    logic [NUM_ENDPOINTS-1:0] rec_valid_reg, rec_valid_next;

    // Output register fields
    logic [EP_W-1:0]   o_ep_reg, o_ep_next;
    logic              o_dir_reg, o_dir_next;
    logic              o_kind_reg, o_kind_next;
    logic              o_sel_reg, o_sel_next;
    logic [MAXP_W-1:0] o_blen_reg, o_blen_next;
    logic              o_pid_reg, o_pid_next;
    logic              o_fin_reg, o_fin_next;
    logic              o_full_reg, o_full_next;
    logic [15:0]       o_uoff_reg, o_uoff_next;
    logic              o_dbl_reg, o_dbl_next;
    logic [15:0]       o_tcnt_reg, o_tcnt_next;
    logic              o_last_reg, o_last_next;

    // RAM ports
    logic              rec_we, rec_re;
    logic [EPW-1:0]    rec_raddr;
    logic [REC_W-1:0]  rec_wdata, rec_rdata;
    logic              lim_we, lim_re;
    logic [TIW-1:0]    lim_waddr, lim_raddr;
    logic [MAXP_W-1:0] lim_rdata;

    // Divider
    logic              div_start, div_done;
    logic [DW-1:0]     div_dividend, div_quot;

    // Arithmetic helpers
    logic [CW-1:0]     in_rem_w, in_len_w, out_len_w, rrem_w, lim_w, rlen_w, rdiff_w;
    logic [LB-1:0]     in_newq;
    logic              in_final;
    logic [DW-1:0]     rsum;
    logic [LB-1:0]     rrecv_sat, rrem_sub, pleft_dec;
    logic              out_done;

    usbet_ram #(
        .WIDTH (REC_W),
        .DEPTH (NUM_ENDPOINTS)
    ) u_rec_ram (
        .clk   (clk),
        .we    (rec_we),
        .waddr (ep_reg),
        .wdata (rec_wdata),
        .re    (rec_re),
        .raddr (rec_raddr),
        .rdata (rec_rdata)
    );

    usbet_ram #(
        .WIDTH (MAXP_W),
        .DEPTH (NT)
    ) u_lim_ram (
        .clk   (clk),
        .we    (lim_we),
        .waddr (lim_waddr),
        .wdata (in_maxp),
        .re    (lim_re),
        .raddr (lim_raddr),
        .rdata (lim_rdata)
    );

    usbet_div #(
        .DW (DW),
        .VW (MAXP_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (lim_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign in_fire   = s_tvalid && s_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = (state_reg == S_EMIT);
    assign rec_wdata = {pleft_reg, rrecv_reg, rrem_reg, queued_reg, total_reg};
    assign rec_raddr = in_ep[EPW-1:0];
    assign lim_waddr = {in_ep[EPW-1:0], in_dir};
    assign div_dividend = DW'(tlen_reg) + DW'(lim_reg) - DW'(1);

    // Buffer length and counter arithmetic
    always_comb
    begin
        lim_w     = CW'(lim_reg);
        rrem_w    = CW'(rrem_reg);
        rlen_w    = CW'(rlen_reg);
        in_rem_w  = CW'(total_reg - queued_reg);
        in_len_w  = (lim_w < in_rem_w) ? lim_w : in_rem_w;
        in_newq   = queued_reg + LB'(in_len_w);
        in_final  = (total_reg <= in_newq);
        out_len_w = (rrem_w < lim_w) ? rrem_w : lim_w;
        rsum      = DW'(rrecv_reg) + DW'(rlen_reg);
        rrecv_sat = (rsum[DW-1:LB] != '0) ? {LB{1'b1}} : rsum[LB-1:0];
        rdiff_w   = rrem_w - rlen_w;
        rrem_sub  = (rrem_w > rlen_w) ? rdiff_w[LB-1:0] : '0;
        pleft_dec = (pleft_reg == '0) ? '0 : pleft_reg - 1'b1;
        out_done  = (pleft_dec == '0) || (rlen_reg < lim_reg);
    end

    // Next state and datapath control
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        ep_next        = ep_reg;
        dir_next       = dir_reg;
        tlen_next      = tlen_reg;
        rlen_next      = rlen_reg;
        total_next     = total_reg;
        queued_next    = queued_reg;
        rrem_next      = rrem_reg;
        rrecv_next     = rrecv_reg;
        pleft_next     = pleft_reg;
        lim_next       = lim_reg;
        second_next    = second_reg;
        pending_next   = pending_reg;
        toggle_next    = toggle_reg;
        rec_valid_next = rec_valid_reg;
        o_ep_next      = o_ep_reg;
        o_dir_next     = o_dir_reg;
        o_kind_next    = o_kind_reg;
        o_sel_next     = o_sel_reg;
        o_blen_next    = o_blen_reg;
        o_pid_next     = o_pid_reg;
        o_fin_next     = o_fin_reg;
        o_full_next    = o_full_reg;
        o_uoff_next    = o_uoff_reg;
        o_dbl_next     = o_dbl_reg;
        o_tcnt_next    = o_tcnt_reg;
        o_last_next    = o_last_reg;
        rec_we         = 1'b0;
        rec_re         = 1'b0;
        lim_we         = 1'b0;
        lim_re         = 1'b0;
        lim_raddr      = {in_ep[EPW-1:0], in_dir};
        div_start      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd_next  = in_cmd;
                    ep_next   = in_ep[EPW-1:0];
                    dir_next  = in_dir;
                    tlen_next = LB'(in_tlen);
                    rlen_next = in_rlen;
                    case (in_cmd)
                        CMD_SETUP:
                        begin
                            toggle_next[0] = 1'b1;
                            toggle_next[1] = 1'b1;
                        end
                        CMD_INIT:
                        begin
                            if (in_ep_ok)
                            begin
                                lim_we = 1'b1;
                                toggle_next[{in_ep[EPW-1:0], in_dir}] = 1'b0;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            if (in_ep_ok)
                            begin
                                toggle_next[{in_ep[EPW-1:0], in_dir}] = 1'b0;
                            end
                        end
                        CMD_START_IN, CMD_START_OUT, CMD_BUF_DONE:
                        begin
                            if (in_ep_ok)
                            begin
                                rec_re = 1'b1;
                                lim_re = 1'b1;
                                if (in_cmd == CMD_START_IN)
                                begin
                                    lim_raddr = {in_ep[EPW-1:0], 1'b1};
                                end
                                else if (in_cmd == CMD_START_OUT)
                                begin
                                    lim_raddr = {in_ep[EPW-1:0], 1'b0};
                                end
                                state_next = S_LOAD;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_LOAD:
            begin
                // Unwritten records read as zero
                if (rec_valid_reg[ep_reg])
                begin
                    total_next  = rec_rdata[LB-1:0];
                    queued_next = rec_rdata[2*LB-1:LB];
                    rrem_next   = rec_rdata[3*LB-1:2*LB];
                    rrecv_next  = rec_rdata[4*LB-1:3*LB];
                    pleft_next  = rec_rdata[5*LB-1:4*LB];
                end
                else
                begin
                    total_next  = '0;
                    queued_next = '0;
                    rrem_next   = '0;
                    rrecv_next  = '0;
                    pleft_next  = '0;
                end
                lim_next     = lim_rdata;
                second_next  = 1'b0;
                pending_next = 1'b0;
                state_next   = S_EXEC;
            end

            S_EXEC:
            begin
                o_ep_next   = EP_W'(ep_reg);
                o_kind_next = KIND_COMPLETE;
                o_sel_next  = 1'b0;
                o_blen_next = '0;
                o_pid_next  = 1'b0;
                o_fin_next  = 1'b0;
                o_full_next = 1'b0;
                o_uoff_next = '0;
                o_dbl_next  = 1'b0;
                o_last_next = 1'b1;
                case (cmd_reg)
                    CMD_START_IN:
                    begin
                        total_next  = tlen_reg;
                        queued_next = '0;
                        state_next  = S_ARM_IN;
                    end
                    CMD_START_OUT:
                    begin
                        rrem_next  = tlen_reg;
                        rrecv_next = '0;
                        if (tlen_reg == '0)
                        begin
                            pleft_next = LB'(1);
                            state_next = S_ARM_OUT;
                        end
                        else if (lim_reg == '0)
                        begin
                            pleft_next = {LB{1'b1}};
                            state_next = S_ARM_OUT;
                        end
                        else
                        begin
                            div_start  = 1'b1;
                            state_next = S_DIV;
                        end
                    end
                    CMD_BUF_DONE:
                    begin
                        if (dir_reg)
                        begin
                            if (total_reg > queued_reg)
                            begin
                                state_next = S_ARM_IN;
                            end
                            else
                            begin
                                o_dir_next  = 1'b1;
                                o_tcnt_next = 16'(queued_reg);
                                state_next  = S_EMIT;
                            end
                        end
                        else
                        begin
                            rrecv_next = rrecv_sat;
                            rrem_next  = rrem_sub;
                            pleft_next = pleft_dec;
                            if (out_done)
                            begin
                                o_dir_next  = 1'b0;
                                o_tcnt_next = 16'(rrecv_sat);
                                state_next  = S_EMIT;
                            end
                            else
                            begin
                                state_next = S_ARM_OUT;
                            end
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_DIV:
            begin
                if (div_done)
                begin
                    pleft_next = div_quot[LB-1:0];
                    state_next = S_ARM_OUT;
                end
            end

            S_ARM_IN:
            begin
                o_ep_next   = EP_W'(ep_reg);
                o_dir_next  = 1'b1;
                o_kind_next = KIND_ARMED;
                o_sel_next  = second_reg;
                o_blen_next = in_len_w[MAXP_W-1:0];
                o_pid_next  = toggle_reg[{ep_reg, 1'b1}];
                o_fin_next  = in_final;
                o_full_next = 1'b1;
                o_uoff_next = 16'(queued_reg);
                o_dbl_next  = second_reg || !in_final;
                o_tcnt_next = '0;
                o_last_next = second_reg || in_final;
                queued_next = in_newq;
                toggle_next[{ep_reg, 1'b1}] = !toggle_reg[{ep_reg, 1'b1}];
                pending_next = !second_reg && !in_final;
                state_next   = S_EMIT;
            end

            S_ARM_OUT:
            begin
                o_ep_next   = EP_W'(ep_reg);
                o_dir_next  = 1'b0;
                o_kind_next = KIND_ARMED;
                o_sel_next  = 1'b0;
                o_blen_next = out_len_w[MAXP_W-1:0];
                o_pid_next  = toggle_reg[{ep_reg, 1'b0}];
                o_fin_next  = (out_len_w >= rrem_w);
                o_full_next = 1'b0;
                o_uoff_next = 16'(rrecv_reg);
                o_dbl_next  = 1'b0;
                o_tcnt_next = '0;
                o_last_next = 1'b1;
                toggle_next[{ep_reg, 1'b0}] = !toggle_reg[{ep_reg, 1'b0}];
                pending_next = 1'b0;
                state_next   = S_EMIT;
            end

            S_EMIT:
            begin
                // Hold the beat until the receiver takes it
                if (m_tready)
                begin
                    if (pending_reg)
                    begin
                        second_next  = 1'b1;
                        pending_next = 1'b0;
                        state_next   = S_ARM_IN;
                    end
                    else
                    begin
                        state_next = S_WB;
                    end
                end
            end

            S_WB:
            begin
                rec_we = 1'b1;
                rec_valid_next[ep_reg] = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            second_reg    <= 1'b0;
            pending_reg   <= 1'b0;
            toggle_reg    <= '0;
            rec_valid_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            second_reg    <= second_next;
            pending_reg   <= pending_next;
            toggle_reg    <= toggle_next;
            rec_valid_reg <= rec_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        ep_reg     <= ep_next;
        dir_reg    <= dir_next;
        tlen_reg   <= tlen_next;
        rlen_reg   <= rlen_next;
        total_reg  <= total_next;
        queued_reg <= queued_next;
        rrem_reg   <= rrem_next;
        rrecv_reg  <= rrecv_next;
        pleft_reg  <= pleft_next;
        lim_reg    <= lim_next;
        o_ep_reg   <= o_ep_next;
        o_dir_reg  <= o_dir_next;
        o_kind_reg <= o_kind_next;
        o_sel_reg  <= o_sel_next;
        o_blen_reg <= o_blen_next;
        o_pid_reg  <= o_pid_next;
        o_fin_reg  <= o_fin_next;
        o_full_reg <= o_full_next;
        o_uoff_reg <= o_uoff_next;
        o_dbl_reg  <= o_dbl_next;
        o_tcnt_reg <= o_tcnt_next;
        o_last_reg <= o_last_next;
    end

    // Pack the result beat
    assign m_tdata = {4'b0, o_tcnt_reg, o_dbl_reg, o_uoff_reg, o_full_reg, o_fin_reg,
                      o_pid_reg, o_blen_reg, o_sel_reg, o_dir_reg, o_ep_reg};
    assign m_tuser = o_kind_reg;
    assign m_tlast = o_last_reg;

endmodule

### hdl/usbet_checker.sv
// Port-level checks for the USB endpoint transfer engine, bound to the top level.
`timescale 1ns / 1ps
module usbet_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [usbet_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic                             m_tuser,
    input logic                             m_tlast
);

    import usbet_pkg::*;

    // Hold a stalled result beat
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result beat changed while stalled");

    // No new command while a result is pending
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("command accepted while a result is pending");

    // Completion ends the run
    a_complete_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_COMPLETE) |-> m_tlast)
        else $error("completion beat without last");

    // Completion carries no buffer description
    a_complete_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_COMPLETE) |-> (m_tdata[35:5] == '0))
        else $error("completion beat with buffer fields set");

    // Second arm of a pair follows a taken first arm
    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> !s_tready)
        else $error("engine idle between the two arms of a pair");

endmodule

bind usb_endpoint_transfer_engine_top usbet_checker u_usbet_checker (.*);
